[sv/cgm_pkg.sv]
// Shared constants and types for the color gradient map.
package cgm_pkg;

  localparam int RANGE_W = 16;
  localparam int CFG_W = 48;
  localparam int CFG_IDX_W = 3;
  localparam int STOP_CNT_W = 4;
  localparam int STOP_IDX_W = 3;
  localparam int STOP_SLOTS = 8;
  localparam int NUM_STOP_REGS = 4;
  localparam int CH_W = 8;
  localparam int NUM_CH = 3;
  localparam int SEG_NUM_W = RANGE_W + STOP_IDX_W;
  localparam int MIX_W = RANGE_W + CH_W;

  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STOPS_01   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STOPS_23   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STOPS_45   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STOPS_67   = 3'd6;

  localparam logic signed [RANGE_W-1:0] RANGE_LOW_RST  = 16'sd0;
  localparam logic signed [RANGE_W-1:0] RANGE_HIGH_RST = 16'sd255;
  localparam logic [STOP_CNT_W-1:0]     STOP_COUNT_RST = 4'd2;
  localparam logic [CFG_W-1:0]          STOPS_01_RST   = 48'hFFFF_FF00_0000;

  // Lane 2 is red, lane 1 green and lane 0 blue.
  typedef logic [NUM_CH-1:0][CH_W-1:0] rgb_t;

  typedef struct packed {
    logic                  interp;
    logic [STOP_IDX_W-1:0] idx;
    logic                  clamp;
  } cgm_ctl_t;

endpackage

[sv/cgm_in_if.sv]
// Input stream interface carrying one signed sample per transfer.
interface cgm_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

[sv/cgm_out_if.sv]
// Output stream interface carrying one RGB color and a clamp flag per transfer.
interface cgm_out_if;
  import cgm_pkg::*;

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;
  logic            clamped;

  modport source (output valid, output red, output green, output blue, output clamped,
                  input ready);
  modport sink (input valid, input red, input green, input blue, input clamped,
                output ready);
endinterface

[sv/color_gradient_map_top.sv]
// Top level of the color gradient map: configuration registers and the mapping pipeline.
//
// Each sample is mapped to an RGB color by linear interpolation between up to eight
// evenly spaced color stops over [range_low, range_high]; samples outside the range take
// the first or last stop and raise clamped. The block takes one sample per clock.
// One stage checks the range and scales the offset, a 3-stage divider finds the segment
// and its remainder, one stage multiplies the two stop colors by their weights, one
// adds them, an 8-stage divider scales each channel back, and the output register
// holds the result. When the output is not taken the whole pipeline holds, and the
// input is stalled with it.
module color_gradient_map_top #(
  parameter int MAX_STOPS   = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cgm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cgm_pkg::CFG_W-1:0]       cfg_wdata_i,
  cgm_in_if.sink                          in_i,
  cgm_out_if.source                       out_o
);
  import cgm_pkg::*;

  localparam int EW = ((SAMPLE_BITS > RANGE_W) ? SAMPLE_BITS : RANGE_W) + 1;
  localparam int CTL_W = $bits(cgm_ctl_t);

  logic signed [RANGE_W-1:0]       range_low_q;
  logic signed [RANGE_W-1:0]       range_high_q;
  logic [STOP_CNT_W-1:0]           stop_count_q;
  logic [NUM_STOP_REGS-1:0][CFG_W-1:0] stop_regs_q;
  rgb_t [STOP_SLOTS-1:0]           stop_tab;
  logic [RANGE_W-1:0]              span;
  logic                            en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q    <= RANGE_LOW_RST;
      range_high_q   <= RANGE_HIGH_RST;
      stop_count_q   <= STOP_COUNT_RST;
      stop_regs_q[0] <= STOPS_01_RST;
      stop_regs_q[1] <= '0;
      stop_regs_q[2] <= '0;
      stop_regs_q[3] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RANGE_LOW:  range_low_q    <= signed'(cfg_wdata_i[RANGE_W-1:0]);
        CFG_RANGE_HIGH: range_high_q   <= signed'(cfg_wdata_i[RANGE_W-1:0]);
        CFG_STOP_COUNT: stop_count_q   <= cfg_wdata_i[STOP_CNT_W-1:0];
        CFG_STOPS_01:   stop_regs_q[0] <= cfg_wdata_i;
        CFG_STOPS_23:   stop_regs_q[1] <= cfg_wdata_i;
        CFG_STOPS_45:   stop_regs_q[2] <= cfg_wdata_i;
        CFG_STOPS_67:   stop_regs_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign stop_tab = stop_regs_q;
  assign span     = RANGE_W'(range_high_q - range_low_q);
  assign en       = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  // Range check and offset scaling.
  logic signed [EW-1:0]      v_ext;
  logic signed [EW-1:0]      low_ext;
  logic signed [EW-1:0]      high_ext;
  logic signed [EW-1:0]      diff;
  logic [STOP_CNT_W-1:0]     n_eff;
  logic [STOP_IDX_W-1:0]     last_idx;
  logic                      below;
  logic                      at_or_above;
  logic                      degenerate;
  cgm_ctl_t                  a_ctl_d;
  logic [SEG_NUM_W-1:0]      a_t_d;

  always_comb begin
    v_ext       = EW'(in_i.sample);
    low_ext     = EW'(range_low_q);
    high_ext    = EW'(range_high_q);
    diff        = v_ext - low_ext;
    n_eff       = (stop_count_q > STOP_CNT_W'(MAX_STOPS)) ? STOP_CNT_W'(MAX_STOPS)
                                                          : stop_count_q;
    last_idx    = STOP_IDX_W'(n_eff - STOP_CNT_W'(1));
    below       = v_ext < low_ext;
    at_or_above = v_ext >= high_ext;
    degenerate  = (n_eff < STOP_CNT_W'(2)) || (range_high_q <= range_low_q);
    a_ctl_d.clamp  = below || (v_ext > high_ext);
    a_ctl_d.interp = !degenerate && !below && !at_or_above;
    a_ctl_d.idx    = (degenerate || below) ? '0 : last_idx;
    a_t_d = SEG_NUM_W'(diff[RANGE_W-1:0]) * SEG_NUM_W'(last_idx);
  end

  logic                 a_valid_q;
  cgm_ctl_t             a_ctl_q;
  logic [SEG_NUM_W-1:0] a_t_q [1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_ctl_q  <= a_ctl_d;
      a_t_q[0] <= a_t_d;
    end
  end

  // Segment and remainder.
  logic                  g_valid;
  logic [STOP_IDX_W-1:0] g_seg [1];
  logic [SEG_NUM_W-1:0]  g_rem [1];
  logic [CTL_W-1:0]      g_side;

  cgm_div #(
    .NUM_W  (SEG_NUM_W),
    .DEN_W  (RANGE_W),
    .QUO_W  (STOP_IDX_W),
    .LANES  (1),
    .SIDE_W (CTL_W)
  ) u_seg_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .den_i   (span),
    .valid_i (a_valid_q),
    .num_i   (a_t_q),
    .side_i  (a_ctl_q),
    .valid_o (g_valid),
    .quo_o   (g_seg),
    .rem_o   (g_rem),
    .side_o  (g_side)
  );

  // Weighted stop colors.
  logic [RANGE_W-1:0]    g_r;
  logic [RANGE_W-1:0]    g_w;
  rgb_t                  g_ca;
  rgb_t                  g_cb;
  logic                  m_valid_q;
  logic [CTL_W-1:0]      m_side_q;
  logic [MIX_W-1:0]      pa_q [NUM_CH];
  logic [MIX_W-1:0]      pb_q [NUM_CH];

  assign g_r  = g_rem[0][RANGE_W-1:0];
  assign g_w  = span - g_r;
  assign g_ca = stop_tab[g_seg[0]];
  assign g_cb = stop_tab[STOP_IDX_W'(g_seg[0] + STOP_IDX_W'(1))];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= g_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_side_q <= g_side;
      for (int c = 0; c < NUM_CH; c++) begin
        pa_q[c] <= MIX_W'(g_w) * MIX_W'(g_ca[c]);
        pb_q[c] <= MIX_W'(g_r) * MIX_W'(g_cb[c]);
      end
    end
  end

  // Numerator sum.
  logic             s_valid_q;
  logic [CTL_W-1:0] s_side_q;
  logic [MIX_W-1:0] s_num_q [NUM_CH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (en) begin
      s_valid_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_side_q <= m_side_q;
      for (int c = 0; c < NUM_CH; c++) begin
        s_num_q[c] <= pa_q[c] + pb_q[c];
      end
    end
  end

  // Channel scaling.
  logic             c_valid;
  logic [CH_W-1:0]  c_quo [NUM_CH];
  logic [MIX_W-1:0] c_rem [NUM_CH];
  logic [CTL_W-1:0] c_side;
  cgm_ctl_t         c_ctl;

  cgm_div #(
    .NUM_W  (MIX_W),
    .DEN_W  (RANGE_W),
    .QUO_W  (CH_W),
    .LANES  (NUM_CH),
    .SIDE_W (CTL_W)
  ) u_ch_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .den_i   (span),
    .valid_i (s_valid_q),
    .num_i   (s_num_q),
    .side_i  (s_side_q),
    .valid_o (c_valid),
    .quo_o   (c_quo),
    .rem_o   (c_rem),
    .side_o  (c_side)
  );

  assign c_ctl = cgm_ctl_t'(c_side);

  // Output register.
  rgb_t color_d;
  logic out_valid_q;
  rgb_t color_q;
  logic clamped_q;

  always_comb begin
    if (c_ctl.interp) begin
      for (int c = 0; c < NUM_CH; c++) begin
        color_d[c] = c_quo[c];
      end
    end else begin
      color_d = stop_tab[c_ctl.idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= c_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      color_q   <= color_d;
      clamped_q <= c_ctl.clamp;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.red     = color_q[2];
  assign out_o.green   = color_q[1];
  assign out_o.blue    = color_q[0];
  assign out_o.clamped = clamped_q;

endmodule

[sv/cgm_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with parallel lanes.
module cgm_div #(
  parameter int NUM_W  = 24,
  parameter int DEN_W  = 16,
  parameter int QUO_W  = 8,
  parameter int LANES  = 3,
  parameter int SIDE_W = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i [LANES],
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [QUO_W-1:0]  quo_o [LANES],
  output logic [NUM_W-1:0]  rem_o [LANES],
  output logic [SIDE_W-1:0] side_o
);

  localparam int CMP_W = NUM_W + DEN_W + QUO_W;

  logic [QUO_W-1:0]  vld_q;
  logic [NUM_W-1:0]  rem_q  [QUO_W][LANES];
  logic [QUO_W-1:0]  quo_q  [QUO_W][LANES];
  logic [SIDE_W-1:0] side_q [QUO_W];
  logic [NUM_W-1:0]  rem_d  [QUO_W][LANES];
  logic [QUO_W-1:0]  quo_d  [QUO_W][LANES];

  always_comb begin
    logic [CMP_W-1:0] cur;
    logic [CMP_W-1:0] trial;
    logic [QUO_W-1:0] cq;
    for (int s = 0; s < QUO_W; s++) begin
      for (int l = 0; l < LANES; l++) begin
        if (s == 0) begin
          cur = CMP_W'(num_i[l]);
          cq  = '0;
        end else begin
          cur = CMP_W'(rem_q[(s == 0) ? 0 : s - 1][l]);
          cq  = quo_q[(s == 0) ? 0 : s - 1][l];
        end
        trial = CMP_W'(den_i) << (QUO_W - 1 - s);
        if (cur >= trial) begin
          rem_d[s][l] = NUM_W'(cur - trial);
          quo_d[s][l] = cq | (QUO_W'(1) << (QUO_W - 1 - s));
        end else begin
          rem_d[s][l] = NUM_W'(cur);
          quo_d[s][l] = cq;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QUO_W-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < QUO_W; s++) begin
        for (int l = 0; l < LANES; l++) begin
          rem_q[s][l] <= rem_d[s][l];
          quo_q[s][l] <= quo_d[s][l];
        end
        side_q[s] <= (s == 0) ? side_i : side_q[(s == 0) ? 0 : s - 1];
      end
    end
  end

  assign valid_o = vld_q[QUO_W-1];
  assign quo_o   = quo_q[QUO_W-1];
  assign rem_o   = rem_q[QUO_W-1];
  assign side_o  = side_q[QUO_W-1];

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the color gradient map: directed table, then random phases.
module testbench;
  import cgm_pkg::*;

  localparam int MAX_STOPS = 8;
  localparam int SAMPLE_BITS = 16;
  localparam int PIPE_LATENCY = 14;
  localparam int RESET_CYCLES = 12;
  localparam int NUM_PHASES = 12;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int NUM_DIR_ROWS = 39;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd7;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  typedef struct packed {
    row_kind_e                     kind;
    logic [CFG_IDX_W-1:0]          idx;
    logic [CFG_W-1:0]              wdata;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          known;
    logic [NUM_CH*CH_W-1:0]        rgb;
    logic                          clamped;
  } dir_row_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            clamped;
  } color_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  cgm_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) sample_ch ();
  cgm_out_if color_ch ();

  color_gradient_map_top #(
    .MAX_STOPS  (MAX_STOPS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (sample_ch),
    .out_o      (color_ch)
  );

  logic signed [RANGE_W-1:0] lo_bound = RANGE_LOW_RST;
  logic signed [RANGE_W-1:0] hi_bound = RANGE_HIGH_RST;
  logic [STOP_CNT_W-1:0] n_stops = STOP_COUNT_RST;
  logic [CFG_W-1:0] stop_pair [NUM_STOP_REGS] = '{STOPS_01_RST, '0, '0, '0};

  color_t expected_colors [$];
  int mismatches = 0;
  int unsigned cycle_cnt = 0;
  int src_gap_pct = 10;
  int sink_stall_pct = 10;
  int stall_menu [4] = '{0, 3, 10, 30};

  dir_row_t dir_rows [NUM_DIR_ROWS] = '{
    '{ROW_SAMPLE, CFG_NONE,       48'h0,              16'h0000, 1'b1, 24'h000000, 1'b0},
    '{ROW_SAMPLE, CFG_NONE,       48'h0,              16'h00FF, 1'b1, 24'hFFFFFF, 1'b0},
    '{ROW_SAMPLE, CFG_NONE,       48'h0,              16'h0080, 1'b0, 24'h000000, 1'b0},
    '{ROW_SAMPLE, CFG_NONE,       48'h0,              16'hFFFF, 1'b1, 24'h000000, 1'b1},
    '{ROW_SAMPLE, CFG_NONE,       48'h0,              16'h0100, 1'b1, 24'hFFFFFF, 1'b1},
    '{ROW_SAMPLE, CFG_NONE,       48'h0,              16'h8000, 1'b1, 24'h000000, 1'b1},
    '{ROW_SAMPLE, CFG_NONE,       48'h0,              16'h7FFF, 1'b1, 24'hFFFFFF, 1'b1},
    '{ROW_WRITE,  CFG_NONE,       48'hFFFF_FFFF_FFFF, 16'h0000, 1'b0, 24'h000000, 1'b0},
    '{ROW_SAMPLE, CFG_NONE,       48'h0,              16'h0000, 1'b1, 24'h000000, 1'b0},
    '{ROW_WRITE,  CFG_RANGE_LOW,  48'hA5A5_5A5A_8000, 16'h0000, 1'b0, 24'h000000, 1'b0},
    '{ROW_WRITE,  CFG_RANGE_HIGH, 48'h5A5A_A5A5_7FFF, 16'h0000, 1'b0, 24'h000000, 1'b0},
    '{ROW_WRITE,  CFG_STOP_COUNT, 48'hFFFF_FFFF_FFF8, 16'h0000, 1'b0, 24'h000000, 1'b0},
    '{ROW_WRITE,  CFG_STOPS_01,   48'h1234_56AB_CDEF, 16'h0000, 1'b0, 24'h000000, 1'b0},
    '{ROW_WRITE,  CFG_STOPS_23,   48'h00FF_00FF_0000, 16'h0000, 1'b0, 24'h000000, 1'b0},
    '{ROW_WRITE,  CFG_STOPS_45,   48'hFFFF_FF00_00FF, 16'h0000, 1'b0, 24'h000000, 1'b0},
    '{ROW_WRITE,  CFG_STOPS_67,   48'hFEDC_BA0F_1E2D, 16'h0000, 1'b0, 24'h000000, 1'b0},
    '{ROW_SAMPLE, CFG_NONE,       48'h0,              16'h8000, 1'b1, 24'hABCDEF, 1'b0},
    '{ROW_SAMPLE, CFG_NONE,       48'h0,              16'h7FFF, 1'b1, 24'hFEDCBA, 1'b0},
    '{ROW_SAMPLE, CFG_NONE,       48'h0,              16'h0000, 1'b0, 24'h000000, 1'b0},
    '{ROW_SAMPLE, CFG_NONE,       48'h0,              16'h7FFE, 1'b0, 24'h000000, 1'b0},
    '{ROW_SAMPLE, CFG_NONE,       48'h0,              16'h8001, 1'b0, 24'h000000, 1'b0},
    '{ROW_WRITE,  CFG_STOP_COUNT, 48'h0000_0000_000F, 16'h0000, 1'b0, 24'h000000, 1'b0},
    '{ROW_SAMPLE, CFG_NONE,       48'h0,              16'h7FFF, 1'b1, 24'hFEDCBA, 1'b0},
    '{ROW_SAMPLE, CFG_NONE,       48'h0,              16'h04D2, 1'b0, 24'h000000, 1'b0},
    '{ROW_WRITE,  CFG_STOP_COUNT, 48'h0000_0000_0001, 16'h0000, 1'b0, 24'h000000, 1'b0},
    '{ROW_SAMPLE, CFG_NONE,       48'h0,              16'h7FFF, 1'b1, 24'hABCDEF, 1'b0},
    '{ROW_WRITE,  CFG_STOP_COUNT, 48'h0000_0000_0000, 16'h0000, 1'b0, 24'h000000, 1'b0},
    '{ROW_SAMPLE, CFG_NONE,       48'h0,              16'hFFFB, 1'b1, 24'hABCDEF, 1'b0},
    '{ROW_WRITE,  CFG_STOP_COUNT, 48'h0000_0000_0003, 16'h0000, 1'b0, 24'h000000, 1'b0},
    '{ROW_WRITE,  CFG_RANGE_LOW,  48'h0000_0000_0064, 16'h0000, 1'b0, 24'h000000, 1'b0},
    '{ROW_WRITE,  CFG_RANGE_HIGH, 48'h0000_0000_0064, 16'h0000, 1'b0, 24'h000000, 1'b0},
    '{ROW_SAMPLE, CFG_NONE,       48'h0,              16'h0064, 1'b1, 24'hABCDEF, 1'b0},
    '{ROW_SAMPLE, CFG_NONE,       48'h0,              16'h0065, 1'b1, 24'hABCDEF, 1'b1},
    '{ROW_SAMPLE, CFG_NONE,       48'h0,              16'h0063, 1'b1, 24'hABCDEF, 1'b1},
    '{ROW_WRITE,  CFG_RANGE_LOW,  48'h0000_0000_00C8, 16'h0000, 1'b0, 24'h000000, 1'b0},
    '{ROW_SAMPLE, CFG_NONE,       48'h0,              16'h0096, 1'b1, 24'hABCDEF, 1'b1},
    '{ROW_WRITE,  CFG_RANGE_HIGH, 48'h0000_0000_00CA, 16'h0000, 1'b0, 24'h000000, 1'b0},
    '{ROW_SAMPLE, CFG_NONE,       48'h0,              16'h00C9, 1'b0, 24'h000000, 1'b0},
    '{ROW_SAMPLE, CFG_NONE,       48'h0,              16'h00CA, 1'b1, 24'hFF0000, 1'b0}
  };

  always #5 clk = ~clk;

  function automatic logic [NUM_CH*CH_W-1:0] stop_rgb(int unsigned k);
    logic [CFG_W-1:0] pair;
    pair = stop_pair[k[2:1]];
    return k[0] ? pair[47:24] : pair[23:0];
  endfunction

  function automatic color_t map_sample(logic signed [SAMPLE_BITS-1:0] s);
    int unsigned n;
    longint span, t, seg, r, mix;
    logic [NUM_CH*CH_W-1:0] a, b, rgb;
    logic clamp;
    n = (n_stops > MAX_STOPS) ? MAX_STOPS : n_stops;
    clamp = (s < lo_bound) || (s > hi_bound);
    if (n < 2 || hi_bound <= lo_bound || s < lo_bound) begin
      rgb = stop_rgb(0);
    end else if (s >= hi_bound) begin
      rgb = stop_rgb(n - 1);
    end else begin
      span = longint'(hi_bound) - longint'(lo_bound);
      t = (longint'(s) - longint'(lo_bound)) * longint'(n - 1);
      seg = t / span;
      r = t % span;
      a = stop_rgb(32'(seg));
      b = stop_rgb(32'(seg + 1));
      for (int ch = 0; ch < NUM_CH; ch++) begin
        mix = ((span - r) * a[ch*CH_W +: CH_W] + r * b[ch*CH_W +: CH_W]) / span;
        rgb[ch*CH_W +: CH_W] = mix[CH_W-1:0];
      end
    end
    return {rgb, clamp};
  endfunction

  function automatic void check_field(string name, logic [CH_W-1:0] want,
                                      logic [CH_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Writes must come only when nothing is in flight; the block does not enforce it, so drain first.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    sample_ch.valid <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_RANGE_LOW:  lo_bound = data[RANGE_W-1:0];
      CFG_RANGE_HIGH: hi_bound = data[RANGE_W-1:0];
      CFG_STOP_COUNT: n_stops = data[STOP_CNT_W-1:0];
      CFG_STOPS_01:   stop_pair[0] = data;
      CFG_STOPS_23:   stop_pair[1] = data;
      CFG_STOPS_45:   stop_pair[2] = data;
      CFG_STOPS_67:   stop_pair[3] = data;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_sample(logic signed [SAMPLE_BITS-1:0] s, color_t want);
    if (src_gap_pct != 0 && $urandom_range(1, 100) <= src_gap_pct) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.sample <= s;
    do @(posedge clk); while (sample_ch.ready !== 1'b1);
    expected_colors.insert(expected_colors.size(), want);
  endtask

  initial begin
    color_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_stall_pct != 0 && $urandom_range(1, 100) <= sink_stall_pct) begin
        color_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      color_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    color_t want;
    if (rst_n && color_ch.valid === 1'b1 && color_ch.ready === 1'b1) begin
      if (expected_colors.size() == 0) begin
        $display("%0t: unexpected transfer, color %02h%02h%02h clamped %0b", $time,
                 color_ch.red, color_ch.green, color_ch.blue, color_ch.clamped);
        mismatches++;
      end else begin
        want = expected_colors.pop_front();
        check_field("red", want.red, color_ch.red);
        check_field("green", want.green, color_ch.green);
        check_field("blue", want.blue, color_ch.blue);
        check_field("clamped", CH_W'(want.clamped), CH_W'(color_ch.clamped));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    sample_ch.valid = 1'b0;
    sample_ch.sample = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      color_t want;
      if (dir_rows[i].kind == ROW_WRITE) begin
        write_reg(dir_rows[i].idx, dir_rows[i].wdata);
      end else begin
        if (dir_rows[i].known) begin
          want = {dir_rows[i].rgb, dir_rows[i].clamped};
        end else begin
          want = map_sample(dir_rows[i].sample);
        end
        push_sample(dir_rows[i].sample, want);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      int lo_v, hi_v, cnt, mode;
      logic signed [SAMPLE_BITS-1:0] s;
      mode = (ph < 5) ? ph : $urandom_range(0, 5);
      cnt = $urandom_range(2, MAX_STOPS);
      case (mode)
        0: begin
          lo_v = -32768;
          hi_v = 32767;
          cnt = MAX_STOPS;
        end
        1: begin
          lo_v = -32768;
          hi_v = 32767;
          cnt = 2;
        end
        2: begin
          lo_v = int'($urandom_range(0, 65527)) - 32768;
          hi_v = lo_v + int'($urandom_range(1, 8));
        end
        3: begin
          lo_v = int'($urandom_range(3, 65535)) - 32768;
          hi_v = lo_v - int'($urandom_range(0, 3));
        end
        default: begin
          lo_v = int'($urandom_range(0, 65535)) - 32768;
          hi_v = int'($urandom_range(0, 65535)) - 32768;
          if (hi_v < lo_v) begin
            {lo_v, hi_v} = {hi_v, lo_v};
          end
          if (mode == 4) begin
            cnt = $urandom_range(0, 15);
          end
        end
      endcase

      write_reg(CFG_RANGE_LOW, {32'($urandom), 16'(lo_v)});
      write_reg(CFG_RANGE_HIGH, {32'($urandom), 16'(hi_v)});
      write_reg(CFG_STOP_COUNT, {44'({$urandom, $urandom}), 4'(cnt)});
      for (int k = 0; k < NUM_STOP_REGS; k++) begin
        write_reg(CFG_IDX_W'(CFG_STOPS_01 + k), 48'({$urandom, $urandom}));
      end

      // The final phase runs with both sides streaming at full rate.
      if (ph == NUM_PHASES - 1) begin
        src_gap_pct = 0;
        sink_stall_pct = 0;
      end else begin
        src_gap_pct = stall_menu[$urandom_range(0, 3)];
        sink_stall_pct = stall_menu[$urandom_range(0, 3)];
      end

      repeat (ITEMS_PER_PHASE) begin
        case ($urandom_range(0, 9))
          0: s = SAMPLE_BITS'($urandom);
          1: begin
            case ($urandom_range(0, 3))
              0: s = lo_bound;
              1: s = hi_bound;
              2: s = lo_bound - 1'b1;
              default: s = hi_bound + 1'b1;
            endcase
          end
          default: begin
            if (hi_bound > lo_bound) begin
              s = SAMPLE_BITS'(int'(lo_bound) +
                  int'($urandom_range(0, int'(hi_bound) - int'(lo_bound))));
            end else begin
              s = SAMPLE_BITS'($urandom);
            end
          end
        endcase
        push_sample(s, map_sample(s));
      end
    end

    sample_ch.valid <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
